// ----- hdl/prpf_pkg.sv -----
// Shared constants, codes and types of the record pattern range finder.
package prpf_pkg;

	localparam int PATTERN_MAX_BYTES = 56;
	localparam int OFFSET_WIDTH      = 20;
	localparam int NUM_WORDS         = 7;
	localparam int STORE_BYTES       = NUM_WORDS * 8;
	localparam int PLEN_W            = 6;
	localparam int BL_W              = $clog2(PATTERN_MAX_BYTES + 1);
	localparam int SEL_W             = $clog2(PATTERN_MAX_BYTES);
	localparam int PADDR_W           = 6;
	localparam int PDATA_W           = 64;
	localparam int REG_IDX_W         = 3;

	localparam logic [7:0] MAGIC_0 = 8'h31;
	localparam logic [7:0] MAGIC_1 = 8'h30;
	localparam logic [7:0] MAGIC_2 = 8'h74;
	localparam logic [7:0] MAGIC_3 = 8'h73;

	localparam logic [REG_IDX_W-1:0] REG_PATTERN_BYTES = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WORD_A        = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WORD_B        = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_WORD_C        = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_WORD_D        = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_WORD_E        = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_WORD_F        = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_WORD_G        = 3'd7;

	localparam logic [PLEN_W-1:0] PATTERN_BYTES_RESET = 6'd2;

	typedef struct packed {
		logic [PLEN_W-1:0]                pat_len;
		logic [STORE_BYTES-1:0][7:0]      pat_bytes;
	} prpf_cfg_t;

	typedef struct packed {
		logic [OFFSET_WIDTH-1:0] range_start;
		logic [OFFSET_WIDTH-1:0] range_end;
		logic                    range_valid;
		logic                    blob_done;
		logic                    offset_overflow;
	} range_word_t;

endpackage

// ----- hdl/prpf_ifs.sv -----
// Stream interfaces for blob bytes and range results.
interface prpf_blob_if import prpf_pkg::*; ();
	logic       valid;
	logic       ready;
	logic [7:0] blob_byte;
	logic       blob_last;

	modport source (output valid, output blob_byte, output blob_last, input ready);
	modport sink (input valid, input blob_byte, input blob_last, output ready);
endinterface

interface prpf_range_if import prpf_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OFFSET_WIDTH-1:0] range_start;
	logic [OFFSET_WIDTH-1:0] range_end;
	logic                    range_valid;
	logic                    blob_done;
	logic                    offset_overflow;

	modport source (output valid, output range_start, output range_end,
		output range_valid, output blob_done, output offset_overflow, input ready);
	modport sink (input valid, input range_start, input range_end,
		input range_valid, input blob_done, input offset_overflow, output ready);
endinterface

// ----- hdl/record_pattern_range_finder.sv -----
// Top level of the record pattern range finder.
//
// Usage: blob bytes enter on the blob channel (valid/ready), one word per
// byte, blob_last marking the final byte. A record opens at each "10ts"
// magic; a record whose body holds the configured pattern gives one word
// on the result channel with its first and last offsets when it closes.
// The final byte of a blob always gives a word, with blob_done set.
// The user must write the pattern over the APB port only while the block
// is idle; the block itself does not enforce this. Throughput: one byte
// per cycle while blob.ready is high. A row of match cells, one per
// pattern byte, advances a prefix match with each byte; the match for the
// configured length is picked from the row in the same cycle. A result
// word is registered when the byte that closes the record is accepted.
// Stall: an output register and a skid register hold up to two words;
// blob.ready drops only while both are full.
// Reset: arst_n clears the stream state, the result buffers and the
// pattern (length two, all bytes zero). After a final byte the stream
// state clears and the next byte starts a new blob at offset zero.
module record_pattern_range_finder import prpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	prpf_blob_if.sink          blob,
	prpf_range_if.source       result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam logic [OFFSET_WIDTH-1:0] OFS_3 = OFFSET_WIDTH'(3);
	localparam logic [OFFSET_WIDTH-1:0] OFS_4 = OFFSET_WIDTH'(4);
	localparam logic [BL_W-1:0]         BL_MAX = BL_W'(PATTERN_MAX_BYTES);
	localparam logic [PLEN_W-1:0]       LEN_MIN = PLEN_W'(2);
	localparam logic [PLEN_W-1:0]       LEN_MAX = PLEN_W'(PATTERN_MAX_BYTES);

	prpf_cfg_t cfg;

	logic                         acc;
	logic [PATTERN_MAX_BYTES-1:0] cell_d;
	logic [PATTERN_MAX_BYTES-1:0] cell_q;
	logic [PLEN_W-1:0]            len_c;
	logic [SEL_W-1:0]             sel;
	logic                         full_match;

	logic [OFFSET_WIDTH-1:0] pos_q, pos_n;
	logic [7:0]              h1_q, h2_q, h3_q;
	logic                    open_q, open_n;
	logic [OFFSET_WIDTH-1:0] rec_begin_q, rec_begin_n;
	logic [BL_W-1:0]         bl_q, bl_n, bl_inc;
	logic                    seen_q, seen_n;
	logic [2:0]              pend_q, pend_n;
	logic                    ovf_q, ovf_n;
	logic                    clr;
	logic                    magic, match_now, hit, emit;
	logic [OFFSET_WIDTH-1:0] start_c, end_c;
	range_word_t             res_d;

	range_word_t out_q, skid_q;
	logic        out_v_q, skid_v_q;
	logic        push, pop;

	prpf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign blob.ready = !skid_v_q;
	assign acc        = blob.valid & blob.ready;

	for (genvar j = 0; j < PATTERN_MAX_BYTES; j++) begin : g_cell
		logic prev;
		if (j == 0) begin : g_first
			assign prev = 1'b1;
		end else begin : g_next
			assign prev = cell_q[j-1];
		end
		prpf_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (acc),
			.blob_byte  (blob.blob_byte),
			.pat_byte   (cfg.pat_bytes[j]),
			.prev_match (prev),
			.match_d    (cell_d[j]),
			.match_q    (cell_q[j])
		);
	end

	always_comb begin
		if (cfg.pat_len < LEN_MIN) begin
			len_c = LEN_MIN;
		end else if (cfg.pat_len > LEN_MAX) begin
			len_c = LEN_MAX;
		end else begin
			len_c = cfg.pat_len;
		end
	end

	assign sel        = SEL_W'(len_c - PLEN_W'(1));
	assign full_match = cell_d[sel];
	assign bl_inc     = (bl_q == BL_MAX) ? bl_q : bl_q + BL_W'(1);
	assign match_now  = (PLEN_W'(bl_inc) >= len_c) && full_match;
	assign magic      = (h3_q == MAGIC_0) && (h2_q == MAGIC_1) && (h1_q == MAGIC_2) &&
		(blob.blob_byte == MAGIC_3);
	assign clr        = blob.blob_last;

	always_comb begin
		open_n      = open_q;
		rec_begin_n = rec_begin_q;
		bl_n        = bl_q;
		seen_n      = seen_q;
		pend_n      = pend_q;
		hit         = 1'b0;
		emit        = 1'b0;
		start_c     = rec_begin_q;
		end_c       = pos_q;
		if (magic) begin
			hit         = open_q && seen_q;
			end_c       = pos_q - OFS_4;
			open_n      = 1'b1;
			rec_begin_n = pos_q - OFS_3;
			bl_n        = '0;
			seen_n      = 1'b0;
			pend_n      = '0;
			emit        = hit || blob.blob_last;
		end else begin
			if (open_q) begin
				bl_n   = bl_inc;
				seen_n = seen_q | pend_q[2];
				pend_n = {pend_q[1:0], match_now};
			end
			if (blob.blob_last) begin
				hit  = open_q && (seen_q || (pend_q != 3'b000) || match_now);
				emit = 1'b1;
			end
		end
		pos_n = pos_q + OFFSET_WIDTH'(1);
		ovf_n = ovf_q | (pos_q == '1);
	end

	always_comb begin
		res_d.range_start     = hit ? start_c : '0;
		res_d.range_end       = hit ? end_c : '0;
		res_d.range_valid     = hit;
		res_d.blob_done       = blob.blob_last;
		res_d.offset_overflow = ovf_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= '0;
			h1_q        <= '0;
			h2_q        <= '0;
			h3_q        <= '0;
			open_q      <= 1'b0;
			rec_begin_q <= '0;
			bl_q        <= '0;
			seen_q      <= 1'b0;
			pend_q      <= '0;
			ovf_q       <= 1'b0;
		end else if (acc) begin
			if (clr) begin
				pos_q       <= '0;
				h1_q        <= '0;
				h2_q        <= '0;
				h3_q        <= '0;
				open_q      <= 1'b0;
				rec_begin_q <= '0;
				bl_q        <= '0;
				seen_q      <= 1'b0;
				pend_q      <= '0;
				ovf_q       <= 1'b0;
			end else begin
				pos_q       <= pos_n;
				h1_q        <= blob.blob_byte;
				h2_q        <= h1_q;
				h3_q        <= h2_q;
				open_q      <= open_n;
				rec_begin_q <= rec_begin_n;
				bl_q        <= bl_n;
				seen_q      <= seen_n;
				pend_q      <= pend_n;
				ovf_q       <= ovf_n;
			end
		end
	end

	assign push = acc & emit;
	assign pop  = out_v_q & result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			if (!out_v_q) begin
				out_v_q <= 1'b1;
			end else begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				out_q <= skid_q;
			end else if (push) begin
				out_q <= res_d;
			end
		end else if (push) begin
			if (!out_v_q) begin
				out_q <= res_d;
			end else begin
				skid_q <= res_d;
			end
		end
	end

	assign result.valid           = out_v_q;
	assign result.range_start     = out_q.range_start;
	assign result.range_end       = out_q.range_end;
	assign result.range_valid     = out_q.range_valid;
	assign result.blob_done       = out_q.blob_done;
	assign result.offset_overflow = out_q.offset_overflow;

endmodule

// ----- hdl/prpf_regs.sv -----
// APB configuration registers: pattern length and pattern bytes.
module prpf_regs import prpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output prpf_cfg_t          cfg
);

	logic [PLEN_W-1:0]               len_q;
	logic [NUM_WORDS-1:0][PDATA_W-1:0] words_q;
	logic [REG_IDX_W-1:0]            idx;
	logic                            wr_en;

	assign idx    = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
	assign pready = 1'b1;
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= PATTERN_BYTES_RESET;
			words_q <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_PATTERN_BYTES: len_q <= pwdata[PLEN_W-1:0];
				REG_WORD_A: words_q[0] <= pwdata;
				REG_WORD_B: words_q[1] <= pwdata;
				REG_WORD_C: words_q[2] <= pwdata;
				REG_WORD_D: words_q[3] <= pwdata;
				REG_WORD_E: words_q[4] <= pwdata;
				REG_WORD_F: words_q[5] <= pwdata;
				REG_WORD_G: words_q[6] <= pwdata;
				default: len_q <= len_q;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PATTERN_BYTES: prdata = {{(PDATA_W-PLEN_W){1'b0}}, len_q};
			REG_WORD_A: prdata = words_q[0];
			REG_WORD_B: prdata = words_q[1];
			REG_WORD_C: prdata = words_q[2];
			REG_WORD_D: prdata = words_q[3];
			REG_WORD_E: prdata = words_q[4];
			REG_WORD_F: prdata = words_q[5];
			REG_WORD_G: prdata = words_q[6];
			default: prdata = '0;
		endcase
	end

	assign cfg.pat_len   = len_q;
	assign cfg.pat_bytes = words_q;

endmodule

// ----- hdl/prpf_cell.sv -----
// One match cell: pattern prefix through this byte ends at the newest blob byte.
module prpf_cell import prpf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] blob_byte,
	input  logic [7:0] pat_byte,
	input  logic       prev_match,
	output logic       match_d,
	output logic       match_q
);

	assign match_d = prev_match & (blob_byte == pat_byte);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (en) begin
			match_q <= match_d;
		end
	end

endmodule

// ----- hdl/prpf_checker.sv -----
// Port checker for the record pattern range finder, with its bind.
module prpf_checker import prpf_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [OFFSET_WIDTH-1:0] range_start,
	input logic [OFFSET_WIDTH-1:0] range_end,
	input logic                    range_valid,
	input logic                    blob_done,
	input logic                    offset_overflow
);

	a_empty_word_is_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !range_valid |-> blob_done && range_start == '0 && range_end == '0)
		else $error("non-matching word away from blob end");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && range_valid && !offset_overflow |->
			range_end >= range_start + OFFSET_WIDTH'(3))
		else $error("record shorter than its magic");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid && $past(out_valid && !out_ready))
		else $error("input stalled with room in the result buffer");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(range_start) &&
			$stable(range_end) && $stable(range_valid) && $stable(blob_done))
		else $error("result word changed while stalled");

endmodule

bind record_pattern_range_finder prpf_checker u_prpf_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_ready        (blob.ready),
	.out_valid       (result.valid),
	.out_ready       (result.ready),
	.range_start     (result.range_start),
	.range_end       (result.range_end),
	.range_valid     (result.range_valid),
	.blob_done       (result.blob_done),
	.offset_overflow (result.offset_overflow)
);

// ----- dv/record_pattern_range_finder_test.sv -----
// Self-checking testbench for the record pattern range finder: byte streams in, range words checked.
module record_pattern_range_finder_test;
	import prpf_pkg::*;

	localparam int CLK_PERIOD      = 10;
	localparam int RESET_CYCLES    = 9;
	localparam int IDLE_MAX        = 18;
	localparam int PHASE_BYTES     = 190;
	localparam int LATENCY_PAUSE   = 4;
	localparam int END_PAUSE       = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int LIMIT_CYCLES    = 500_000;
	localparam int HIST_BITS       = PATTERN_MAX_BYTES * 8;
	localparam int PRINT_CAP       = 40;

	typedef enum int {PAT_RANDOM, PAT_TEXT, PAT_ONES, PAT_ZEROS} pattern_style_e;

	class range_scoreboard;
		logic [PLEN_W-1:0]       len_reg;
		logic [7:0]              pat_store [STORE_BYTES];
		logic [HIST_BITS-1:0]    history;
		logic [OFFSET_WIDTH-1:0] next_offset;
		logic [OFFSET_WIDTH-1:0] open_start;
		int                      body_len;
		bit                      in_record;
		bit                      pattern_found;
		logic [2:0]              recent_hits;
		bit                      wrapped;
		range_word_t             pending_ranges [$];
		int                      mismatches;
		int                      bytes_seen;
		int                      blobs_seen;
		int                      words_checked;
		int                      matches_checked;
		int                      wrapped_checked;

		function new();
			len_reg = PATTERN_BYTES_RESET;
			foreach (pat_store[i]) pat_store[i] = 8'h00;
			clear_blob();
		endfunction

		function void clear_blob();
			next_offset   = '0;
			history       = '0;
			in_record     = 1'b0;
			open_start    = '0;
			body_len      = 0;
			pattern_found = 1'b0;
			recent_hits   = '0;
			wrapped       = 1'b0;
		endfunction

		function void set_register(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] v);
			if (idx == REG_PATTERN_BYTES) begin
				len_reg = v[PLEN_W-1:0];
			end else begin
				for (int j = 0; j < 8; j++)
					pat_store[(int'(idx) - int'(REG_WORD_A)) * 8 + j] = v[8*j +: 8];
			end
		endfunction

		function int effective_len();
			int n;
			n = int'(len_reg);
			if (n < 2)
				n = 2;
			if (n > PATTERN_MAX_BYTES)
				n = PATTERN_MAX_BYTES;
			return n;
		endfunction

		function logic [7:0] pattern_at(int i);
			return pat_store[i];
		endfunction

		function bit pattern_ends_here(int n);
			for (int i = 0; i < n; i++) begin
				if (pat_store[i] != history[8*(n-1-i) +: 8])
					return 1'b0;
			end
			return 1'b1;
		endfunction

		function void predict_byte(logic [7:0] b, logic fin);
			logic [OFFSET_WIDTH-1:0] pos;
			logic [OFFSET_WIDTH-1:0] first_off;
			logic [OFFSET_WIDTH-1:0] last_off;
			bit                      was_wrapped;
			bit                      closes;
			bit                      hit;
			bit                      emit;
			bit                      ends_match;
			int                      n;
			range_word_t             want;
			pos         = next_offset;
			was_wrapped = wrapped;
			n           = effective_len();
			hit         = 1'b0;
			emit        = 1'b0;
			first_off   = '0;
			last_off    = '0;
			bytes_seen++;
			history = {history[HIST_BITS-9:0], b};
			closes  = history[31:0] == {MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
			if (closes) begin
				hit           = in_record && pattern_found;
				first_off     = open_start;
				last_off      = pos - OFFSET_WIDTH'(4);
				in_record     = 1'b1;
				open_start    = pos - OFFSET_WIDTH'(3);
				body_len      = 0;
				pattern_found = 1'b0;
				recent_hits   = '0;
				emit          = hit || fin;
			end else begin
				if (in_record) begin
					if (body_len < PATTERN_MAX_BYTES)
						body_len++;
					ends_match = body_len >= n && pattern_ends_here(n);
					if (recent_hits[2])
						pattern_found = 1'b1;
					recent_hits = {recent_hits[1:0], ends_match};
				end
				if (fin) begin
					hit       = in_record && (pattern_found || recent_hits != '0);
					first_off = open_start;
					last_off  = pos;
					emit      = 1'b1;
				end
			end
			next_offset = pos + OFFSET_WIDTH'(1);
			if (next_offset == '0)
				wrapped = 1'b1;
			if (fin) begin
				blobs_seen++;
				clear_blob();
			end
			if (emit) begin
				want.range_start     = hit ? first_off : '0;
				want.range_end       = hit ? last_off : '0;
				want.range_valid     = hit;
				want.blob_done       = fin;
				want.offset_overflow = was_wrapped;
				pending_ranges.push_back(want);
			end
		endfunction

		task report_mismatch(string what);
			mismatches++;
			if (mismatches <= PRINT_CAP)
				$display("%0t mismatch: %s", $time, what);
		endtask

		task check_range(range_word_t got);
			range_word_t want;
			if (pending_ranges.size() == 0) begin
				report_mismatch($sformatf("range word %h with none outstanding", got));
				return;
			end
			want = pending_ranges.pop_front();
			words_checked++;
			if (want.range_valid)
				matches_checked++;
			if (want.offset_overflow)
				wrapped_checked++;
			if (got.range_start !== want.range_start)
				report_mismatch($sformatf("range_start %h, want %h",
					got.range_start, want.range_start));
			if (got.range_end !== want.range_end)
				report_mismatch($sformatf("range_end %h, want %h",
					got.range_end, want.range_end));
			if (got.range_valid !== want.range_valid)
				report_mismatch($sformatf("range_valid %b, want %b",
					got.range_valid, want.range_valid));
			if (got.blob_done !== want.blob_done)
				report_mismatch($sformatf("blob_done %b, want %b",
					got.blob_done, want.blob_done));
			if (got.offset_overflow !== want.offset_overflow)
				report_mismatch($sformatf("offset_overflow %b, want %b",
					got.offset_overflow, want.offset_overflow));
		endtask
	endclass

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	prpf_blob_if  blob_ch ();
	prpf_range_if range_ch ();

	range_scoreboard sb = new();
	logic [7:0]      blob_q [$];
	int              src_idle_max = 0;
	int              snk_idle_max = 0;
	int              hold_off_len = 0;
	int              bytes_sent = 0;
	int              cycle_count = 0;

	record_pattern_range_finder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.blob    (blob_ch),
		.result  (range_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial clk = 1'b0;
	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("record_pattern_range_finder_test: FAIL");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && blob_ch.valid && blob_ch.ready)
			sb.predict_byte(blob_ch.blob_byte, blob_ch.blob_last);
	end

	always @(posedge clk) begin
		range_word_t got;
		if (arst_n && range_ch.valid && range_ch.ready) begin
			got.range_start     = range_ch.range_start;
			got.range_end       = range_ch.range_end;
			got.range_valid     = range_ch.range_valid;
			got.blob_done       = range_ch.blob_done;
			got.offset_overflow = range_ch.offset_overflow;
			sb.check_range(got);
		end
	end

	initial begin
		int wait_len;
		range_ch.ready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			// hold ready low so that range words back up and stall the byte input
			if (hold_off_len > 0) begin
				range_ch.ready <= 1'b0;
				repeat (hold_off_len) @(negedge clk);
				hold_off_len = 0;
			end
			wait_len = $urandom_range(0, snk_idle_max);
			if (wait_len > 0) begin
				range_ch.ready <= 1'b0;
				repeat (wait_len) @(negedge clk);
			end
			range_ch.ready <= 1'b1;
			@(posedge clk);
			while (!range_ch.valid) @(posedge clk);
			@(negedge clk);
		end
	end

	function automatic logic [7:0] magic_char(int i);
		case (i)
			0:       return MAGIC_0;
			1:       return MAGIC_1;
			2:       return MAGIC_2;
			default: return MAGIC_3;
		endcase
	endfunction

	function automatic logic [7:0] text_byte();
		case ($urandom_range(0, 5))
			0, 1, 2, 3: return magic_char($urandom_range(0, 3));
			4:          return 8'h00;
			default:    return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return magic_char($urandom_range(0, 3));
			4, 5, 6:    return sb.pattern_at($urandom_range(0, sb.effective_len() - 1));
			default:    return 8'($urandom);
		endcase
	endfunction

	function automatic void add_magic();
		for (int i = 0; i < 4; i++)
			blob_q.push_back(magic_char(i));
	endfunction

	function automatic void add_noise(int count);
		repeat (count) blob_q.push_back(noise_byte());
	endfunction

	function automatic void add_record(int body, bit with_pattern);
		logic [7:0] body_q [$];
		int         n;
		int         keep;
		int         at;
		n = sb.effective_len();
		add_magic();
		repeat (body) body_q.push_back(noise_byte());
		if (with_pattern && body > 0) begin
			keep = (body >= n) ? n : body;
			if (keep > 1 && $urandom_range(0, 5) == 0)
				keep--;
			at = $urandom_range(0, body - keep);
			for (int j = 0; j < keep; j++)
				body_q[at + j] = sb.pattern_at(j);
		end
		foreach (body_q[j]) blob_q.push_back(body_q[j]);
	endfunction

	function automatic void make_blob(int records);
		int n;
		n = sb.effective_len();
		case ($urandom_range(0, 3))
			0: add_noise($urandom_range(1, 4));
			1: begin
				blob_q.push_back(MAGIC_0);
				blob_q.push_back(MAGIC_1);
				blob_q.push_back(MAGIC_2);
				add_noise(1);
			end
			default: ;
		endcase
		repeat (records) begin
			add_record($urandom_range(0, 1) ? $urandom_range(n, n + 6) : $urandom_range(0, n + 6),
				$urandom_range(0, 3) != 0);
		end
		if ($urandom_range(0, 4) == 0)
			add_magic();
		if (blob_q.size() == 0)
			add_noise(1);
	endfunction

	function automatic int pick_idle();
		case ($urandom_range(0, 3))
			0:       return 0;
			1:       return 4;
			default: return IDLE_MAX;
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic fin);
		int gap;
		gap = $urandom_range(0, src_idle_max);
		if (gap > 0) begin
			blob_ch.valid     <= 1'b0;
			blob_ch.blob_byte <= 8'($urandom);
			blob_ch.blob_last <= 1'($urandom);
			repeat (gap) @(negedge clk);
		end
		blob_ch.valid     <= 1'b1;
		blob_ch.blob_byte <= b;
		blob_ch.blob_last <= fin;
		@(posedge clk);
		while (!blob_ch.ready) @(posedge clk);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_blob();
		for (int j = 0; j < blob_q.size(); j++)
			send_byte(blob_q[j], j == blob_q.size() - 1);
		blob_q.delete();
	endtask

	task automatic drain_ranges(input int settle);
		blob_ch.valid <= 1'b0;
		@(negedge clk);
		while (sb.pending_ranges.size() != 0) @(negedge clk);
		repeat (settle) @(negedge clk);
	endtask

	task automatic access_reg(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] v);
		logic [PDATA_W-1:0] mask;
		mask = (idx == REG_PATTERN_BYTES) ? PDATA_W'((1 << PLEN_W) - 1) : '1;
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		sb.set_register(idx, v);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if ((prdata & mask) !== (v & mask))
			sb.report_mismatch($sformatf("register %0d reads %h, want %h",
				idx, prdata & mask, v & mask));
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input logic [PLEN_W-1:0] raw_len, input pattern_style_e style);
		logic [PDATA_W-1:0] w;
		drain_ranges(LATENCY_PAUSE);
		w = {$urandom, $urandom};
		w[PLEN_W-1:0] = raw_len;
		access_reg(REG_PATTERN_BYTES, w);
		for (int k = 0; k < NUM_WORDS; k++) begin
			case (style)
				PAT_RANDOM: w = {$urandom, $urandom};
				PAT_ONES:   w = '1;
				PAT_ZEROS:  w = '0;
				default: begin
					for (int j = 0; j < 8; j++)
						w[8*j +: 8] = text_byte();
				end
			endcase
			access_reg(REG_IDX_W'(REG_WORD_A + k), w);
		end
	endtask

	task automatic run_phase(input logic [PLEN_W-1:0] raw_len, input pattern_style_e style,
		input bit pause_midway);
		int  first_sent;
		bit  paused;
		configure(raw_len, style);
		src_idle_max = pick_idle();
		snk_idle_max = pick_idle();
		first_sent   = bytes_sent;
		paused       = 1'b0;
		while (bytes_sent - first_sent < PHASE_BYTES) begin
			make_blob($urandom_range(0, 4));
			send_blob();
			if (pause_midway && !paused && bytes_sent - first_sent >= PHASE_BYTES / 2) begin
				drain_ranges(0);
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		arst_n             = 1'b0;
		psel               = 1'b0;
		penable            = 1'b0;
		pwrite             = 1'b0;
		paddr              = '0;
		pwdata             = '0;
		blob_ch.valid      = 1'b0;
		blob_ch.blob_byte  = 8'h00;
		blob_ch.blob_last  = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_max = IDLE_MAX;
		snk_idle_max = IDLE_MAX;
		blob_q = '{8'h78, MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, 8'h00, 8'h00};
		send_blob();
		blob_q = '{8'h41};
		send_blob();

		drain_ranges(LATENCY_PAUSE);
		access_reg(REG_PATTERN_BYTES, 64'd4);
		access_reg(REG_WORD_A, 64'h0000_0000_00ff_00ff);
		blob_q = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, 8'hff, 8'h00, 8'hff, 8'h00,
			MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
		send_blob();

		// a match made of the next magic's own bytes must be dropped
		drain_ranges(LATENCY_PAUSE);
		access_reg(REG_PATTERN_BYTES, 64'd2);
		access_reg(REG_WORD_A, PDATA_W'({MAGIC_1, MAGIC_0}));
		blob_q = '{MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3, MAGIC_0, MAGIC_1, MAGIC_2, MAGIC_3};
		send_blob();

		run_phase(6'd2, PAT_RANDOM, 1'b0);
		run_phase(6'd56, PAT_RANDOM, 1'b0);
		run_phase(6'd0, PAT_TEXT, 1'b1);
		run_phase(6'd63, PAT_TEXT, 1'b0);
		run_phase(6'd1, PAT_ONES, 1'b0);
		run_phase(PLEN_W'($urandom_range(3, 12)), PAT_TEXT, 1'b0);
		run_phase(PLEN_W'($urandom_range(2, 56)), PAT_RANDOM, 1'b0);
		run_phase(PLEN_W'($urandom_range(57, 62)), PAT_ZEROS, 1'b0);
		run_phase(6'd8, PAT_ONES, 1'b0);

		configure(6'd2, PAT_TEXT);
		src_idle_max = 0;
		snk_idle_max = 0;
		hold_off_len = HOLD_OFF_CYCLES;
		repeat (40) begin
			add_noise($urandom_range(1, 3));
			send_blob();
		end

		drain_ranges(END_PAUSE);
		$display("covered %0d bytes in %0d blobs, %0d range words checked (%0d matching)",
			sb.bytes_seen, sb.blobs_seen, sb.words_checked, sb.matches_checked);
		$display("pattern lengths 2 to 56 incl. out-of-range settings, %0d words past offset wrap",
			sb.wrapped_checked);
		if (sb.mismatches == 0) begin
			$display("record_pattern_range_finder_test: PASS");
		end else begin
			$display("record_pattern_range_finder_test: FAIL");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/prpf_pkg.sv
hdl/prpf_ifs.sv
hdl/prpf_regs.sv
hdl/prpf_cell.sv
hdl/record_pattern_range_finder.sv
hdl/prpf_checker.sv
dv/record_pattern_range_finder_test.sv
